// ===== rtl/lrbc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lrbc_pkg
// Shared types and constants for the LR4 biquad cascade unit.
// ----------------------------------------------------------------------------
package lrbc_pkg;

  localparam int SAMPLE_BITS    = 24;
  localparam int COEF_FRAC_BITS = 30;
  localparam int COEF_BITS      = 32;
  localparam int COEF_COUNT     = 5;
  localparam int CFG_IDX_BITS   = 3;
  localparam int PROD_BITS      = COEF_BITS + SAMPLE_BITS;
  localparam int ACC_BITS       = 64;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [COEF_BITS-1:0]   coef_t;
  typedef logic signed [PROD_BITS-1:0]   prod_t;
  typedef logic signed [ACC_BITS-1:0]    acc_t;

  // register indexes; also the tap order of one biquad pass
  typedef enum logic [CFG_IDX_BITS-1:0] {
    COEF_B0 = 3'd0,
    COEF_B1 = 3'd1,
    COEF_B2 = 3'd2,
    COEF_A1 = 3'd3,
    COEF_A2 = 3'd4
  } coef_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DRAIN,
    ST_ROUND,
    ST_DONE
  } lrbc_state_e;

  typedef struct packed {
    logic clr;     // start a new accumulation
    logic mul_en;  // issue one product
    logic sub;     // product is a feedback term
  } mac_ctl_t;

  localparam coef_t COEF_ONE   = coef_t'(1) <<< COEF_FRAC_BITS;
  localparam acc_t  ROUND_HALF = acc_t'(1) <<< (COEF_FRAC_BITS - 1);
  localparam acc_t  SAT_HI     = (acc_t'(1) <<< (SAMPLE_BITS - 1)) - acc_t'(1);
  localparam acc_t  SAT_LO     = -(acc_t'(1) <<< (SAMPLE_BITS - 1));

endpackage
`default_nettype wire

// ===== rtl/lrbc_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lrbc_if
// Valid/ready channels for sample words into and out of the cascade unit.
// ----------------------------------------------------------------------------
interface lrbc_in_if;
  logic              valid;
  logic              ready;
  lrbc_pkg::sample_t sample_in;
  logic              block_last_in;

  modport source(output valid, output sample_in, output block_last_in, input ready);
  modport sink(input valid, input sample_in, input block_last_in, output ready);
endinterface

interface lrbc_out_if;
  logic              valid;
  logic              ready;
  lrbc_pkg::sample_t sample_out;
  logic              block_last_out;

  modport source(output valid, output sample_out, output block_last_out, input ready);
  modport sink(input valid, input sample_out, input block_last_out, output ready);
endinterface
`default_nettype wire

// ===== rtl/linkwitz_riley_biquad_cascade_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// linkwitz_riley_biquad_cascade_unit
// Fourth-order Linkwitz-Riley filter: two direct-form-I biquads in cascade
// sharing one coefficient set, on one shared multiply-accumulate unit.
// ----------------------------------------------------------------------------
// Usage:
//   in_if carries one sample word plus a block-end marker; out_if returns one
//   filtered word per input word, marker copied through. Coefficients b0..a2
//   (signed Q2.30) are written on cfg_we_i/cfg_idx_i/cfg_data_i while idle.
//   Each word runs, per stage, five products through the single 32x24
//   multiplier (ST_MUL), an accumulate drain step (ST_DRAIN) and a
//   round/saturate step (ST_ROUND); then the writeback step (ST_DONE).
//   in_if.ready is high only while the sequencer is idle, so a new word is
//   not taken until the last one has been written back. The output
//   register holds a finished word while the next one is accepted and
//   filtered; if the receiver still stalls at writeback, the sequencer waits
//   there and the filter history is not advanced until the output register
//   frees up.
//   Reset clears all history to zero and loads b0 = 1.0, others 0
//   (pass-through).
// ----------------------------------------------------------------------------
module linkwitz_riley_biquad_cascade_unit (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_we_i,
  input  wire logic [lrbc_pkg::CFG_IDX_BITS-1:0]   cfg_idx_i,
  input  wire logic [lrbc_pkg::COEF_BITS-1:0]      cfg_data_i,
  lrbc_in_if.sink                                  in_if,
  lrbc_out_if.source                               out_if
);
  import lrbc_pkg::*;

  lrbc_state_e state_q, state_d;
  coef_idx_e   step_q, step_d;
  logic        stage_q, stage_d;

  coef_t    coef [COEF_COUNT];
  mac_ctl_t mac_ctl;
  coef_t    mac_coef;
  sample_t  mac_opnd;
  sample_t  mac_y;

  sample_t x_q, y1_q, y2_q;
  logic    last_q;
  sample_t in_h0_q, in_h1_q, o1_h0_q, o1_h1_q, o2_h0_q, o2_h1_q;
  sample_t out_sample_q;
  logic    out_last_q;
  logic    out_valid_q;

  logic accept;
  logic load_y1;
  logic load_y2;
  logic wb;

  lrbc_coef_regs u_coef_regs (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i,
    .coef_o (coef)
  );

  lrbc_mac u_mac (
    .clk_i,
    .rst_ni,
    .ctl_i  (mac_ctl),
    .coef_i (mac_coef),
    .opnd_i (mac_opnd),
    .y_o    (mac_y)
  );

  assign in_if.ready = (state_q == ST_IDLE);
  assign accept      = in_if.valid && in_if.ready;

  // operand select: stage two's input history is stage one's output history
  always_comb begin
    mac_coef = coef[step_q];
    unique case (step_q)
      COEF_B0: mac_opnd = stage_q ? y1_q    : x_q;
      COEF_B1: mac_opnd = stage_q ? o1_h0_q : in_h0_q;
      COEF_B2: mac_opnd = stage_q ? o1_h1_q : in_h1_q;
      COEF_A1: mac_opnd = stage_q ? o2_h0_q : o1_h0_q;
      COEF_A2: mac_opnd = stage_q ? o2_h1_q : o1_h1_q;
      default: mac_opnd = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= COEF_B0;
      stage_q <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      stage_q <= stage_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    stage_d     = stage_q;
    mac_ctl     = '0;
    load_y1     = 1'b0;
    load_y2     = 1'b0;
    wb          = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_MUL;
          step_d  = COEF_B0;
          stage_d = 1'b0;
        end
      end
      ST_MUL: begin
        mac_ctl.mul_en = 1'b1;
        mac_ctl.clr    = (step_q == COEF_B0);
        mac_ctl.sub    = (step_q == COEF_A1) || (step_q == COEF_A2);
        if (step_q == COEF_A2) begin
          state_d = ST_DRAIN;
        end else begin
          step_d = coef_idx_e'(step_q + 3'd1);
        end
      end
      ST_DRAIN: begin
        state_d = ST_ROUND;
      end
      ST_ROUND: begin
        if (!stage_q) begin
          load_y1 = 1'b1;
          stage_d = 1'b1;
          step_d  = COEF_B0;
          state_d = ST_MUL;
        end else begin
          load_y2 = 1'b1;
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || out_if.ready) begin
          wb      = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      x_q    <= in_if.sample_in;
      last_q <= in_if.block_last_in;
    end
    if (load_y1) begin
      y1_q <= mac_y;
    end
    if (load_y2) begin
      y2_q <= mac_y;
    end
    if (wb) begin
      out_sample_q <= y2_q;
      out_last_q   <= last_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_h0_q     <= '0;
      in_h1_q     <= '0;
      o1_h0_q     <= '0;
      o1_h1_q     <= '0;
      o2_h0_q     <= '0;
      o2_h1_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (wb) begin
        in_h1_q     <= in_h0_q;
        in_h0_q     <= x_q;
        o1_h1_q     <= o1_h0_q;
        o1_h0_q     <= y1_q;
        o2_h1_q     <= o2_h0_q;
        o2_h0_q     <= y2_q;
        out_valid_q <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_if.valid          = out_valid_q;
  assign out_if.sample_out     = out_sample_q;
  assign out_if.block_last_out = out_last_q;

endmodule
`default_nettype wire

// ===== rtl/lrbc_coef_regs.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lrbc_coef_regs
// Coefficient register file, written through the plain config port.
// ----------------------------------------------------------------------------
module lrbc_coef_regs (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_we_i,
  input  wire logic [lrbc_pkg::CFG_IDX_BITS-1:0]   cfg_idx_i,
  input  wire logic [lrbc_pkg::COEF_BITS-1:0]      cfg_data_i,
  output lrbc_pkg::coef_t                          coef_o [lrbc_pkg::COEF_COUNT]
);
  import lrbc_pkg::*;

  coef_t coef_q [COEF_COUNT];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q[COEF_B0] <= COEF_ONE;
      coef_q[COEF_B1] <= '0;
      coef_q[COEF_B2] <= '0;
      coef_q[COEF_A1] <= '0;
      coef_q[COEF_A2] <= '0;
    end else if (cfg_we_i) begin
      unique case (coef_idx_e'(cfg_idx_i))
        COEF_B0: coef_q[COEF_B0] <= coef_t'(cfg_data_i);
        COEF_B1: coef_q[COEF_B1] <= coef_t'(cfg_data_i);
        COEF_B2: coef_q[COEF_B2] <= coef_t'(cfg_data_i);
        COEF_A1: coef_q[COEF_A1] <= coef_t'(cfg_data_i);
        COEF_A2: coef_q[COEF_A2] <= coef_t'(cfg_data_i);
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  assign coef_o = coef_q;

endmodule
`default_nettype wire

// ===== rtl/lrbc_mac.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lrbc_mac
// Shared multiply-accumulate unit with round-half-up and saturation.
// ----------------------------------------------------------------------------
module lrbc_mac (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire lrbc_pkg::mac_ctl_t ctl_i,
  input  wire lrbc_pkg::coef_t    coef_i,
  input  wire lrbc_pkg::sample_t  opnd_i,
  output lrbc_pkg::sample_t       y_o
);
  import lrbc_pkg::*;

  prod_t prod;
  prod_t p_q;
  logic  pv_q;
  logic  sub_q;
  acc_t  acc_q;
  acc_t  acc_d;
  acc_t  addend;
  acc_t  rnd;
  acc_t  shf;

  assign prod = coef_i * opnd_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q  <= 1'b0;
      sub_q <= 1'b0;
    end else begin
      pv_q  <= ctl_i.mul_en;
      sub_q <= ctl_i.sub;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.mul_en) begin
      p_q <= prod;
    end
    acc_q <= acc_d;
  end

  always_comb begin
    addend = acc_t'(p_q);
    if (!pv_q) begin
      acc_d = ctl_i.clr ? '0 : acc_q;
    end else if (sub_q) begin
      acc_d = (ctl_i.clr ? '0 : acc_q) - addend;
    end else begin
      acc_d = (ctl_i.clr ? '0 : acc_q) + addend;
    end
  end

  // round half up, then clamp to the sample range
  assign rnd = acc_q + ROUND_HALF;
  assign shf = rnd >>> COEF_FRAC_BITS;

  always_comb begin
    if (shf > SAT_HI) begin
      y_o = SAT_HI[SAMPLE_BITS-1:0];
    end else if (shf < SAT_LO) begin
      y_o = SAT_LO[SAMPLE_BITS-1:0];
    end else begin
      y_o = shf[SAMPLE_BITS-1:0];
    end
  end

endmodule
`default_nettype wire
